// File: design/mtd_pkg.sv
package mtd_pkg;

  // Input range: first tick past the end of year 9999
  localparam logic [48:0] TICK_LIMIT = 49'd315537897600000;

  // Whole days: ms/86400000 = (ms >> 10) / 84375, estimated by reciprocal then corrected
  localparam int          DAY_SHIFT  = 39;
  localparam logic [16:0] DAY_ODD    = 17'd84375;
  localparam logic [22:0] DAY_RECIP  = 23'((64'd1 << DAY_SHIFT) / 64'd84375);

  // Calendar cycle lengths in days
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [17:0] DAYS_100Y  = 18'd36524;
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [10:0] DAYS_1Y    = 11'd365;

  // Exact reciprocals (ceil) for the cycle divisions
  localparam int          Y400_SHIFT = 40;
  localparam logic [22:0] Y400_RECIP = 23'(((64'd1 << Y400_SHIFT) + 64'd146096) / 64'd146097);
  localparam int          Y4_SHIFT   = 27;
  localparam logic [16:0] Y4_RECIP   = 17'(((64'd1 << Y4_SHIFT) + 64'd1460) / 64'd1461);

  // Time of day: each divisor split into a power of two and an odd part
  localparam logic [21:0] MS_HOUR    = 22'd3600000;
  localparam int          HOUR_SHIFT = 35;
  localparam logic [20:0] HOUR_RECIP = 21'(((64'd1 << HOUR_SHIFT) + 64'd28124) / 64'd28125);
  localparam logic [15:0] MS_MINUTE  = 16'd60000;
  localparam int          MIN_SHIFT  = 28;
  localparam logic [17:0] MIN_RECIP  = 18'(((64'd1 << MIN_SHIFT) + 64'd1874) / 64'd1875);
  localparam logic [9:0]  MS_SECOND  = 10'd1000;
  localparam int          SEC_SHIFT  = 20;
  localparam logic [13:0] SEC_RECIP  = 14'(((64'd1 << SEC_SHIFT) + 64'd124) / 64'd125);

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millis;
  } tod_t;

  // Days in the year before the first of month m, leap years shifted after February
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && (m > 4'd1)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// File: design/mtd_day_split.sv
module mtd_day_split (
  input  logic        clk,
  input  logic        adv,
  input  logic [48:0] tick_i,
  output logic [21:0] days_o,
  output logic [26:0] ms_o
);
  import mtd_pkg::*;

  logic [38:0] q;
  logic [54:0] pp_lo_r;
  logic [29:0] pp_hi_r;
  logic [38:0] q1_r, q2_r;
  logic [9:0]  lo1_r, lo2_r, lo3_r;
  logic [61:0] sum;
  logic [22:0] est2_r, est3_r;
  logic [39:0] back;
  logic [39:0] diff;
  logic [17:0] rem3_r;
  logic        over;
  logic [22:0] days_full;
  logic [17:0] rem_fix;
  logic [21:0] days_r;
  logic [26:0] ms_r;

  assign q = tick_i[48:10];

  // Partial products of the day reciprocal
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_lo_r <= 55'(q[31:0]) * 55'(DAY_RECIP);
      pp_hi_r <= 30'(q[38:32]) * 30'(DAY_RECIP);
      q1_r    <= q;
      lo1_r   <= tick_i[9:0];
    end
  end

  // Sum partial products, keep the day estimate
  assign sum = {pp_hi_r, 32'd0} + {7'd0, pp_lo_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      est2_r <= sum[61:DAY_SHIFT];
      q2_r   <= q1_r;
      lo2_r  <= lo1_r;
    end
  end

  // Remainder of the estimate, below twice the divisor
  assign back = 40'(est2_r) * 40'(DAY_ODD);
  assign diff = {1'b0, q2_r} - back;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem3_r <= diff[17:0];
      est3_r <= est2_r;
      lo3_r  <= lo2_r;
    end
  end

  // Correct a low estimate by one
  assign over      = (rem3_r >= {1'b0, DAY_ODD});
  assign days_full = est3_r + 23'(over);
  assign rem_fix   = over ? (rem3_r - {1'b0, DAY_ODD}) : rem3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      days_r <= days_full[21:0];
      ms_r   <= {rem_fix[16:0], lo3_r};
    end
  end

  assign days_o = days_r;
  assign ms_o   = ms_r;

endmodule

// File: design/mtd_calendar.sv
module mtd_calendar (
  input  logic          clk,
  input  logic          adv,
  input  logic [21:0]   days_i,
  output mtd_pkg::date_t date_o
);
  import mtd_pkg::*;

  logic [44:0] p400_r;
  logic [21:0] days1_r;
  logic [4:0]  n400;
  logic [22:0] sub400;
  logic [22:0] r400;
  logic [4:0]  n400_2_r, n400_3_r, n400_4_r, n400_5_r;
  logic [17:0] r2_r;
  logic [1:0]  n100;
  logic [17:0] sub100;
  logic [17:0] r100;
  logic [1:0]  n100_3_r, n100_4_r, n100_5_r;
  logic [15:0] r3_r, r4_r;
  logic [32:0] p4_r;
  logic [4:0]  n4;
  logic [15:0] sub4;
  logic [15:0] r4y;
  logic [4:0]  n4_5_r;
  logic [10:0] r5_r;
  logic [1:0]  n1;
  logic [10:0] sub1;
  logic [10:0] r1y;
  logic [13:0] year;
  logic        leap;
  logic [13:0] year6_r;
  logic        leap6_r;
  logic [8:0]  r6_r;
  logic [3:0]  month;
  logic [8:0]  mstart;
  logic [8:0]  dday;
  date_t       date_r;

  // 400-year cycles: reciprocal product
  always_ff @(posedge clk) begin
    if (adv) begin
      p400_r  <= 45'(days_i) * 45'(Y400_RECIP);
      days1_r <= days_i;
    end
  end

  // 400-year count and remainder
  assign n400   = p400_r[44:Y400_SHIFT];
  assign sub400 = 23'(n400) * 23'(DAYS_400Y);
  assign r400   = {1'b0, days1_r} - sub400;

  always_ff @(posedge clk) begin
    if (adv) begin
      n400_2_r <= n400;
      r2_r     <= r400[17:0];
    end
  end

  // Centuries, capped at 3 on the last day of the cycle
  always_comb begin
    priority if (r2_r >= 18'(3 * DAYS_100Y)) begin
      n100 = 2'd3;
    end else if (r2_r >= 18'(2 * DAYS_100Y)) begin
      n100 = 2'd2;
    end else if (r2_r >= DAYS_100Y) begin
      n100 = 2'd1;
    end else begin
      n100 = 2'd0;
    end
  end
  assign sub100 = 18'(n100) * DAYS_100Y;
  assign r100   = r2_r - sub100;

  always_ff @(posedge clk) begin
    if (adv) begin
      n400_3_r <= n400_2_r;
      n100_3_r <= n100;
      r3_r     <= r100[15:0];
    end
  end

  // 4-year cycles: reciprocal product
  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r     <= 33'(r3_r) * 33'(Y4_RECIP);
      r4_r     <= r3_r;
      n400_4_r <= n400_3_r;
      n100_4_r <= n100_3_r;
    end
  end

  // 4-year count and remainder
  assign n4   = p4_r[31:Y4_SHIFT];
  assign sub4 = 16'(n4) * 16'(DAYS_4Y);
  assign r4y  = r4_r - sub4;

  always_ff @(posedge clk) begin
    if (adv) begin
      n400_5_r <= n400_4_r;
      n100_5_r <= n100_4_r;
      n4_5_r   <= n4;
      r5_r     <= r4y[10:0];
    end
  end

  // Single years, capped at 3 on the last day of a 4-year cycle
  always_comb begin
    priority if (r5_r >= 11'(3 * DAYS_1Y)) begin
      n1 = 2'd3;
    end else if (r5_r >= 11'(2 * DAYS_1Y)) begin
      n1 = 2'd2;
    end else if (r5_r >= DAYS_1Y) begin
      n1 = 2'd1;
    end else begin
      n1 = 2'd0;
    end
  end
  assign sub1 = 11'(n1) * DAYS_1Y;
  assign r1y  = r5_r - sub1;
  assign year = 14'(n400_5_r) * 14'd400 + 14'(n100_5_r) * 14'd100
              + 14'(n4_5_r) * 14'd4 + 14'(n1);
  // Leap: fourth year of a 4-year cycle, except a century year not on a 400 boundary
  assign leap = (n1 == 2'd3) && ((n4_5_r != 5'd24) || (n100_5_r == 2'd3));

  always_ff @(posedge clk) begin
    if (adv) begin
      year6_r <= year;
      leap6_r <= leap;
      r6_r    <= r1y[8:0];
    end
  end

  // Month: last month whose start is not past the day of year
  always_comb begin
    month = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (r6_r >= month_start(4'(m), leap6_r)) begin
        month = 4'(m);
      end
    end
  end
  assign mstart = month_start(month, leap6_r);
  assign dday   = r6_r - mstart;

  always_ff @(posedge clk) begin
    if (adv) begin
      date_r.year  <= year6_r;
      date_r.month <= month;
      date_r.day   <= dday[4:0];
    end
  end

  assign date_o = date_r;

endmodule

// File: design/mtd_clock.sv
module mtd_clock (
  input  logic         clk,
  input  logic         adv,
  input  logic [26:0]  ms_i,
  output mtd_pkg::tod_t tod_o
);
  import mtd_pkg::*;

  logic [40:0] ph_r;
  logic [26:0] ms1_r;
  logic [4:0]  hour;
  logic [26:0] subh;
  logic [26:0] msh;
  logic [4:0]  hour2_r, hour3_r, hour4_r, hour5_r, hour6_r;
  logic [21:0] ms2_r, ms3_r;
  logic [34:0] pm_r;
  logic [5:0]  minute;
  logic [21:0] subm;
  logic [21:0] msm;
  logic [5:0]  min4_r, min5_r, min6_r;
  logic [15:0] ms4_r, ms5_r;
  logic [26:0] ps_r;
  logic [5:0]  second;
  logic [15:0] subs;
  logic [15:0] mss;
  logic [5:0]  sec6_r;
  logic [9:0]  ms6_r;
  tod_t        tod_r;

  // Hours: reciprocal product on ms / 128
  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r  <= 41'(ms_i[26:7]) * 41'(HOUR_RECIP);
      ms1_r <= ms_i;
    end
  end

  assign hour = ph_r[39:HOUR_SHIFT];
  assign subh = 27'(hour) * 27'(MS_HOUR);
  assign msh  = ms1_r - subh;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour2_r <= hour;
      ms2_r   <= msh[21:0];
    end
  end

  // Minutes: reciprocal product on ms / 32
  always_ff @(posedge clk) begin
    if (adv) begin
      pm_r    <= 35'(ms2_r[21:5]) * 35'(MIN_RECIP);
      ms3_r   <= ms2_r;
      hour3_r <= hour2_r;
    end
  end

  assign minute = pm_r[33:MIN_SHIFT];
  assign subm   = 22'(minute) * 22'(MS_MINUTE);
  assign msm    = ms3_r - subm;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour4_r <= hour3_r;
      min4_r  <= minute;
      ms4_r   <= msm[15:0];
    end
  end

  // Seconds: reciprocal product on ms / 8
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r    <= 27'(ms4_r[15:3]) * 27'(SEC_RECIP);
      ms5_r   <= ms4_r;
      hour5_r <= hour4_r;
      min5_r  <= min4_r;
    end
  end

  assign second = ps_r[25:SEC_SHIFT];
  assign subs   = 16'(second) * 16'(MS_SECOND);
  assign mss    = ms5_r - subs;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= second;
      ms6_r   <= mss[9:0];
    end
  end

  // Hold one more stage to line up with the calendar path
  always_ff @(posedge clk) begin
    if (adv) begin
      tod_r.hour   <= hour6_r;
      tod_r.minute <= min6_r;
      tod_r.second <= sec6_r;
      tod_r.millis <= ms6_r;
    end
  end

  assign tod_o = tod_r;

endmodule

// File: design/millisecond_ticks_to_date_top.sv
// Millisecond tick count to proleptic Gregorian date and time of day.
//
// Input channel: in_valid / in_stall with in_tick_count, the milliseconds
// since 0001-01-01 00:00:00.000. Result channel: out_valid / out_stall with
// zero-based year, month and day, plus hour, minute, second and millisecond.
// A count past the end of year 9999 gives out_out_of_range = 1 and all other
// fields zero. Every item gives exactly one result item.
//
// The block is a 13-register pipeline: input register, four stages that
// split off whole days, seven stages where the calendar and clock paths run
// side by side, and the result register. One item is accepted every cycle
// while the receiver does not stall. The depth is set by the chain of
// reciprocal multiplies, each followed by a register.
//
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost. Reset clears all valid
// bits, so the pipeline comes up empty and ready. in_stall stays high while
// reset is held, so no item is taken during reset.
module millisecond_ticks_to_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [48:0] in_tick_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_year_index,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_index,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute,
  output logic [9:0]  out_millis_of_second,
  output logic        out_out_of_range
);
  import mtd_pkg::*;

  localparam int DEPTH = 12;

  logic             adv;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] oor_r;
  logic [48:0]      tick_r;
  logic [21:0]      days;
  logic [26:0]      ms_day;
  date_t            date;
  tod_t             tod;
  logic             out_valid_r;
  date_t            date_out_r;
  tod_t             tod_out_r;
  logic             oor_out_r;

  // Advance everything unless a finished result is held by the receiver
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv || !rst_n;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  // Input register and range flag alongside the data
  always_ff @(posedge clk) begin
    if (adv) begin
      tick_r <= in_tick_count;
      oor_r  <= {oor_r[DEPTH-2:0], (in_tick_count >= TICK_LIMIT)};
    end
  end

  mtd_day_split u_split (
    .clk    (clk),
    .adv    (adv),
    .tick_i (tick_r),
    .days_o (days),
    .ms_o   (ms_day)
  );

  mtd_calendar u_cal (
    .clk    (clk),
    .adv    (adv),
    .days_i (days),
    .date_o (date)
  );

  mtd_clock u_clk (
    .clk   (clk),
    .adv   (adv),
    .ms_i  (ms_day),
    .tod_o (tod)
  );

  // Result register: zero the fields of an out-of-range item
  always_ff @(posedge clk) begin
    if (adv) begin
      oor_out_r <= oor_r[DEPTH-1];
      if (oor_r[DEPTH-1]) begin
        date_out_r <= '0;
        tod_out_r  <= '0;
      end else begin
        date_out_r <= date;
        tod_out_r  <= tod;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_year_index       = date_out_r.year;
  assign out_month_index      = date_out_r.month;
  assign out_day_index        = date_out_r.day;
  assign out_hour_of_day      = tod_out_r.hour;
  assign out_minute_of_hour   = tod_out_r.minute;
  assign out_second_of_minute = tod_out_r.second;
  assign out_millis_of_second = tod_out_r.millis;
  assign out_out_of_range     = oor_out_r;

endmodule
